// File: hdl/multi_key_debounce_long_press_top_defines.svh
// Assertion macros for the multi-key debounce block.
// Included by the top level only; no other dependencies.
`ifndef MULTI_KEY_DEBOUNCE_LONG_PRESS_TOP_DEFINES_SVH
`define MULTI_KEY_DEBOUNCE_LONG_PRESS_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define MKD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MKD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/mkd_pkg.sv
// Shared types and constants for the multi-key debounce block.
// No dependencies; used by all RTL files of the block.
package mkd_pkg;

  localparam int KEY_W      = 3;
  localparam int NUM_IDX    = 2 ** KEY_W;
  localparam int NUM_KEYS_D = 8;
  localparam int FT_W       = 7;
  localparam int FC_W       = 8;
  localparam int LT_W       = 16;
  localparam int MASK_W     = 8;
  localparam int KIND_W     = 2;
  localparam int ST_W       = 2;
  localparam int EVQ_DEPTH  = 4;
  localparam int EVQ_PTR_W  = 2;
  localparam int EVQ_CNT_W  = 3;

  localparam logic [FT_W-1:0] RESET_FILTER_TIME = 7'd5;
  localparam logic [LT_W-1:0] RESET_LONG_TIME   = 16'd100;
  localparam logic [FC_W-1:0] RESET_FILTER_CNT  = 8'(RESET_FILTER_TIME / 2);

  // register indexes
  localparam logic [1:0] REG_FILTER_TIME = 2'd0;
  localparam logic [1:0] REG_LONG_TIME   = 2'd1;
  localparam logic [1:0] REG_ACTIVE_MASK = 2'd2;

  // key state codes
  localparam logic [ST_W-1:0] ST_NOTHING = 2'd0;
  localparam logic [ST_W-1:0] ST_DOWN    = 2'd1;
  localparam logic [ST_W-1:0] ST_LONG    = 2'd2;

  // event kinds
  localparam logic [KIND_W-1:0] EV_DOWN = 2'd0;
  localparam logic [KIND_W-1:0] EV_LONG = 2'd1;
  localparam logic [KIND_W-1:0] EV_UP   = 2'd2;

  typedef struct packed {
    logic [FT_W-1:0]   filter_time;
    logic [LT_W-1:0]   long_time;
    logic [MASK_W-1:0] active_mask;
  } cfg_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key_id;
    logic [KIND_W-1:0] kind;
    logic              last;
  } event_t;

  typedef struct packed {
    logic [1:0] num;   // 0, 1 or 2 events
    event_t     ev0;
    event_t     ev1;
  } ev_push_t;

endpackage

// File: hdl/mkd_core.sv
// Per-key debounce filter, hold counter and pressed state; one
// read-modify-write per tick. Depends on mkd_pkg.
module mkd_core #(
  parameter int NUM_KEYS = mkd_pkg::NUM_KEYS_D
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mkd_pkg::cfg_t            cfg,
  input  logic                     tick_fire,
  input  logic [mkd_pkg::KEY_W-1:0] tick_key,
  input  logic                     tick_pin,
  output mkd_pkg::ev_push_t        push
);

  localparam int DEPTH = (NUM_KEYS < mkd_pkg::NUM_IDX) ? NUM_KEYS : mkd_pkg::NUM_IDX;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [mkd_pkg::FC_W-1:0] fc_r [DEPTH];
  logic [mkd_pkg::LT_W-1:0] hc_r [DEPTH];
  logic [mkd_pkg::ST_W-1:0] st_r [DEPTH];

  logic [IDX_W-1:0]          idx;
  logic                      in_range;
  logic                      active;
  logic [mkd_pkg::FC_W-1:0]  fc, fc_nxt, ft, ft2;
  logic [mkd_pkg::LT_W-1:0]  hc, hc_nxt, hc_inc;
  logic [mkd_pkg::ST_W-1:0]  st, st_nxt;
  logic                      ev_dn, ev_lg, ev_up;

  assign idx      = tick_key[IDX_W-1:0];
  assign in_range = 32'(tick_key) < 32'(NUM_KEYS);
  assign active   = tick_pin == cfg.active_mask[tick_key];
  assign ft       = {1'b0, cfg.filter_time};
  assign ft2      = {cfg.filter_time, 1'b0};
  assign fc       = fc_r[idx];
  assign hc       = hc_r[idx];
  assign st       = st_r[idx];
  assign hc_inc   = hc + 16'd1;

  always_comb begin
    fc_nxt = fc;
    hc_nxt = hc;
    st_nxt = st;
    ev_dn  = 1'b0;
    ev_lg  = 1'b0;
    ev_up  = 1'b0;
    if (active) begin
      if (fc < ft) begin
        fc_nxt = ft;
      end else if (fc < ft2) begin
        fc_nxt = fc + 8'd1;
      end else begin
        // press established
        if (st == mkd_pkg::ST_NOTHING) begin
          st_nxt = mkd_pkg::ST_DOWN;
          ev_dn  = 1'b1;
        end
        if (cfg.long_time != '0 && hc < cfg.long_time) begin
          hc_nxt = hc_inc;
          if (hc_inc == cfg.long_time) begin
            st_nxt = mkd_pkg::ST_LONG;
            ev_lg  = 1'b1;
          end
        end
      end
    end else begin
      if (fc > ft) begin
        fc_nxt = ft;
      end else if (fc != '0) begin
        fc_nxt = fc - 8'd1;
      end else if (st != mkd_pkg::ST_NOTHING) begin
        st_nxt = mkd_pkg::ST_NOTHING;
        ev_up  = 1'b1;
      end
      hc_nxt = '0;
    end
  end

  always_comb begin
    push         = '0;
    push.ev0.key_id = tick_key;
    push.ev1.key_id = tick_key;
    push.ev1.kind   = mkd_pkg::EV_LONG;
    push.ev1.last   = 1'b1;
    push.ev0.last   = 1'b1;
    if (tick_fire && in_range) begin
      if (ev_dn && ev_lg) begin
        push.num      = 2'd2;
        push.ev0.kind = mkd_pkg::EV_DOWN;
        push.ev0.last = 1'b0;
      end else if (ev_dn) begin
        push.num      = 2'd1;
        push.ev0.kind = mkd_pkg::EV_DOWN;
      end else if (ev_lg) begin
        push.num      = 2'd1;
        push.ev0.kind = mkd_pkg::EV_LONG;
      end else if (ev_up) begin
        push.num      = 2'd1;
        push.ev0.kind = mkd_pkg::EV_UP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DEPTH; k++) begin
        fc_r[k] <= mkd_pkg::RESET_FILTER_CNT;
        hc_r[k] <= mkd_pkg::RESET_LONG_TIME;
        st_r[k] <= mkd_pkg::ST_NOTHING;
      end
    end else if (tick_fire && in_range) begin
      fc_r[idx] <= fc_nxt;
      hc_r[idx] <= hc_nxt;
      st_r[idx] <= st_nxt;
    end
  end

endmodule

// File: hdl/mkd_evq.sv
// Small event queue between the key logic and the result channel;
// takes up to two events per cycle, gives one. Depends on mkd_pkg.
module mkd_evq (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mkd_pkg::ev_push_t             push,
  input  logic                          pop,
  output logic                          room,
  output logic                          not_empty,
  output mkd_pkg::event_t               head,
  output logic [mkd_pkg::EVQ_CNT_W-1:0] count
);

  mkd_pkg::event_t mem_r [mkd_pkg::EVQ_DEPTH];

  logic [mkd_pkg::EVQ_PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt, wr_p1;
  logic [mkd_pkg::EVQ_CNT_W-1:0] cnt_r, cnt_nxt;

  assign wr_p1     = wr_r + 2'd1;
  assign not_empty = cnt_r != '0;
  assign head      = mem_r[rd_r];
  assign count     = cnt_r;
  // room for a worst-case tick of two events
  assign room      = cnt_r <= 3'(mkd_pkg::EVQ_DEPTH - 2);

  always_comb begin
    wr_nxt  = wr_r + push.num;
    rd_nxt  = rd_r + {1'b0, pop};
    cnt_nxt = cnt_r + {1'b0, push.num} - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem_r[wr_r] <= push.ev0;
    end
    if (push.num == 2'd2) begin
      mem_r[wr_p1] <= push.ev1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hdl/multi_key_debounce_long_press_top.sv
// Top level of the multi-key debounce and long-press block: config
// registers, input register, key logic and event queue. Depends on mkd_pkg,
// mkd_core, mkd_evq and the assertion macro header.
//
//  channel | direction | contents
//  in_     | slave     | tdata: key_index[2:0], pin_level[3]
//  out_    | master    | tdata: key_id[2:0]; tuser: event_kind[1:0]; tlast: last
//  cfg_    | APB slave | 0x0 filter_time, 0x4 long_time, 0x8 active_level_mask
//
// A tick is registered on acceptance and processed once the queue has room:
// one read-modify-write of that key's counters, up to two events into a
// four-entry queue. One tick per cycle while the queue has room for two
// events; results leave at one per cycle while out_tready is high. Reset is
// synchronous, all counters preset, no clearing pass. out_tready low backs
// up through the queue to in_tready.
`include "multi_key_debounce_long_press_top_defines.svh"

module multi_key_debounce_long_press_top #(
  parameter int NUM_KEYS = mkd_pkg::NUM_KEYS_D
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // key_index[2:0], pin_level[3], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // key_id[2:0], zero pad
  output logic [1:0]  out_tuser,  // event_kind[1:0]
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  mkd_pkg::cfg_t cfg_r;

  logic                       t_valid_r;
  logic [mkd_pkg::KEY_W-1:0]  t_key_r;
  logic                       t_pin_r;
  logic                       t_fire;
  logic                       cfg_wr;
  logic [1:0]                 cfg_idx;

  mkd_pkg::ev_push_t             push;
  mkd_pkg::event_t               head;
  logic                          room, not_empty, pop;
  logic [mkd_pkg::EVQ_CNT_W-1:0] q_count;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_idx)
      mkd_pkg::REG_FILTER_TIME: cfg_prdata = 32'(cfg_r.filter_time);
      mkd_pkg::REG_LONG_TIME:   cfg_prdata = 32'(cfg_r.long_time);
      mkd_pkg::REG_ACTIVE_MASK: cfg_prdata = 32'(cfg_r.active_mask);
      default:                  cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.filter_time <= mkd_pkg::RESET_FILTER_TIME;
      cfg_r.long_time   <= mkd_pkg::RESET_LONG_TIME;
      cfg_r.active_mask <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        mkd_pkg::REG_FILTER_TIME: cfg_r.filter_time <= cfg_pwdata[mkd_pkg::FT_W-1:0];
        mkd_pkg::REG_LONG_TIME:   cfg_r.long_time   <= cfg_pwdata[mkd_pkg::LT_W-1:0];
        mkd_pkg::REG_ACTIVE_MASK: cfg_r.active_mask <= cfg_pwdata[mkd_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  assign t_fire    = t_valid_r && room;
  assign in_tready = !t_valid_r || room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_valid_r <= 1'b0;
    end else if (in_tready) begin
      t_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      t_key_r <= in_tdata[mkd_pkg::KEY_W-1:0];
      t_pin_r <= in_tdata[mkd_pkg::KEY_W];
    end
  end

  mkd_core #(
    .NUM_KEYS (NUM_KEYS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .tick_fire (t_fire),
    .tick_key  (t_key_r),
    .tick_pin  (t_pin_r),
    .push      (push)
  );

  assign pop = not_empty && out_tready;

  mkd_evq u_evq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .room      (room),
    .not_empty (not_empty),
    .head      (head),
    .count     (q_count)
  );

  assign out_tvalid = not_empty;
  assign out_tdata  = {5'b00000, head.key_id};
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;

  // checks
  `MKD_ASSERT_NOW(a_kind_legal, clk, rst_n, out_tvalid, out_tuser <= mkd_pkg::EV_UP,
                  "illegal event kind on output")
  `MKD_ASSERT_NOW(a_pair_order, clk, rst_n, push.num == 2'd2,
                  push.ev0.kind == mkd_pkg::EV_DOWN && push.ev1.kind == mkd_pkg::EV_LONG,
                  "two events per tick must be down then long")
  `MKD_ASSERT_NEXT(a_tick_held, clk, rst_n, in_tvalid && in_tready, t_valid_r,
                   "accepted tick not registered")
  `MKD_ASSERT_NOW(a_no_overflow, clk, rst_n, push.num != 2'd0,
                  q_count <= 3'(mkd_pkg::EVQ_DEPTH - 2),
                  "event queue pushed without room")

endmodule
